### sv/pfs_pkg.sv
// shared types, constants and helpers for the potential field steering unit
`default_nettype none
package pfs_pkg;

    localparam int RNG_W = 24;
    localparam int ANG_W = 23;
    localparam int CFG_W = 32;
    localparam int IDX_W = 3;
    localparam int NUM_W = 37;
    localparam int CORDIC_STEPS = 16;

    localparam logic signed [ANG_W-1:0] HALF_PI_LIM = 23'sd102943;
    localparam logic signed [ANG_W-1:0] PI_Q16 = 23'sd205887;
    localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;
    localparam logic signed [20:0] INV_MM2 = 21'sd1000000;
    localparam logic signed [15:0] ANG_LIM = 16'sd16384;

    typedef enum logic [IDX_W-1:0] {
        REG_SCALE_X   = 3'd0,
        REG_SCALE_Y   = 3'd1,
        REG_OFFSET_X  = 3'd2,
        REG_OFFSET_Y  = 3'd3,
        REG_SPEED_G   = 3'd4,
        REG_STEER_P   = 3'd5,
        REG_STEER_D   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [CFG_W-1:0] scale_x;
        logic signed [CFG_W-1:0] scale_y;
        logic signed [CFG_W-1:0] offset_x;
        logic signed [CFG_W-1:0] offset_y;
        logic signed [CFG_W-1:0] speed_gain;
        logic signed [CFG_W-1:0] steer_p_gain;
        logic signed [CFG_W-1:0] steer_d_gain;
    } t_cfg;

    typedef struct packed {
        logic                    contrib;
        logic                    last;
        logic [RNG_W-1:0]        rng;
        logic signed [ANG_W-1:0] ang;
    } t_sample;

    function automatic logic [15:0] atan_q16(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd51472;
            4'd1:    v = 16'd30385;
            4'd2:    v = 16'd16055;
            4'd3:    v = 16'd8150;
            4'd4:    v = 16'd4091;
            4'd5:    v = 16'd2047;
            4'd6:    v = 16'd1024;
            4'd7:    v = 16'd512;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd128;
            4'd10:   v = 16'd64;
            4'd11:   v = 16'd32;
            4'd12:   v = 16'd16;
            4'd13:   v = 16'd8;
            4'd14:   v = 16'd4;
            default: v = 16'd2;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/pfs_sample_if.sv
// lidar sample channel
`default_nettype none
interface pfs_sample_if #(
    parameter int RANGE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [RANGE_BITS-1:0] range_mm;
    logic signed [15:0]    beam_angle;
    logic                  last_sample;

    modport source (output valid, range_mm, beam_angle, last_sample, input ready);
    modport sink   (input valid, range_mm, beam_angle, last_sample, output ready);
endinterface
`default_nettype wire

### sv/pfs_cmd_if.sv
// speed and steering command channel
`default_nettype none
interface pfs_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] speed_cmd;
    logic signed [31:0] steering_cmd;

    modport source (output valid, speed_cmd, steering_cmd, input ready);
    modport sink   (input valid, speed_cmd, steering_cmd, output ready);
endinterface
`default_nettype wire

### sv/pfs_front.sv
// sample intake: classifies each item and queues it for the force engine
`default_nettype none
module pfs_front #(
    parameter int RANGE_BITS = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    pfs_sample_if.sink       i_smp,
    output logic             o_q_valid,
    output pfs_pkg::t_sample o_q_data,
    input  wire              i_q_pop
);
    import pfs_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);
    localparam logic [RANGE_BITS-1:0] RMAX = '1;

    t_sample               r_mem [DEPTH];
    logic [PW-1:0]         r_wp;
    logic [PW-1:0]         r_rp;
    logic [PW:0]           r_cnt;
    logic signed [ANG_W-1:0] w_a16;
    logic                  w_push;
    t_sample               w_item;

    assign w_a16 = ANG_W'(i_smp.beam_angle) <<< (16 - ANGLE_FRAC_BITS);

    always_comb begin
        w_item.contrib = (i_smp.range_mm != '0) && (i_smp.range_mm != RMAX) &&
                         (w_a16 >= -HALF_PI_LIM) && (w_a16 <= HALF_PI_LIM);
        w_item.last    = i_smp.last_sample;
        w_item.rng     = RNG_W'(i_smp.range_mm);
        w_item.ang     = w_a16;
    end

    assign i_smp.ready = (r_cnt != (PW+1)'(DEPTH));
    assign w_push      = i_smp.valid && i_smp.ready;
    assign o_q_valid   = (r_cnt != '0);
    assign o_q_data    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

endmodule
`default_nettype wire

### sv/pfs_back.sv
// force engine: cordic, divider, accumulators and end-of-scan command sequencer
`default_nettype none
module pfs_back #(
    parameter int RANGE_BITS = 16,
    parameter int ACC_BITS = 48
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_q_valid,
    input  pfs_pkg::t_sample i_q_data,
    output logic             o_q_pop,
    input  pfs_pkg::t_cfg    i_cfg,
    pfs_cmd_if.source        o_cmd
);
    import pfs_pkg::*;

    localparam int DEN_W = 2 * RANGE_BITS;
    localparam int SW = ((ACC_BITS > NUM_W + 1) ? ACC_BITS : NUM_W + 1) + 1;
    localparam logic signed [SW-1:0] ACC_MAX = $signed((SW'(1) << (ACC_BITS - 1)) - SW'(1));
    localparam logic signed [SW-1:0] ACC_MIN = -ACC_MAX - SW'(1);
    localparam int VW = 36;
    localparam logic [40:0] SCL_LIM = 41'h100_0000_0000;

    typedef enum logic [3:0] {
        S_IDLE, S_ROT, S_MUL, S_DIV, S_ACC, S_SC1, S_SC2, S_SC3,
        S_VI, S_SQ, S_VEC, S_ANG, S_PRD, S_OUT
    } t_state;

    t_state                  r_state;
    logic [5:0]              r_cnt;
    logic                    r_last;
    logic [RANGE_BITS-1:0]   r_rng;
    logic signed [19:0]      r_cx, r_cy;
    logic signed [ANG_W-1:0] r_z;
    logic [NUM_W-1:0]        r_qx, r_qy;
    logic [DEN_W-1:0]        r_remx, r_remy, r_den;
    logic                    r_negx, r_negy;
    logic signed [ACC_BITS-1:0] r_sx, r_sy;
    logic signed [15:0]      r_prev;
    logic [63:0]             r_phx, r_plx, r_phy, r_ply;
    logic                    r_sgx, r_sgy;
    logic [40:0]             r_mgx, r_mgy;
    logic signed [31:0]      r_nx, r_ny;
    logic signed [VW-1:0]    r_vx, r_vy;
    logic                    r_byp;
    logic [63:0]             r_sqx, r_sqy, r_v, r_r, r_bit;
    logic signed [15:0]      r_ang;
    logic [31:0]             r_mag;
    logic [63:0]             r_spp;
    logic                    r_spneg;
    logic signed [47:0]      r_stp;
    logic signed [48:0]      r_std;
    logic                    r_out_valid;
    logic signed [31:0]      r_spd, r_str;

    logic [3:0]              w_i;
    logic signed [ANG_W-1:0] w_atan;
    logic signed [40:0]      w_px, w_py;
    logic [DEN_W:0]          w_tx, w_ty;
    logic                    w_gx, w_gy;
    logic [63:0]             w_ax, w_ay;
    logic [31:0]             w_bx, w_by;
    logic [48:0]             w_fx, w_fy;
    logic signed [42:0]      w_ox, w_oy;
    logic [63:0]             w_rb;
    logic signed [ANG_W-1:0] w_zh;
    logic [31:0]             w_bg;
    logic signed [16:0]      w_dang;
    logic signed [63:0]      w_sp;
    logic signed [49:0]      w_st;
    logic                    w_out_ok;

    function automatic logic signed [ACC_BITS-1:0] sat_acc(
        input logic signed [ACC_BITS-1:0] s,
        input logic [NUM_W-1:0]           q,
        input logic                       pos
    );
        logic signed [SW-1:0] t;
        logic signed [SW-1:0] r;
        t = pos ? $signed(SW'(q)) : -$signed(SW'(q));
        r = SW'(s) + t;
        if (r > ACC_MAX) begin
            r = ACC_MAX;
        end else if (r < ACC_MIN) begin
            r = ACC_MIN;
        end
        return r[ACC_BITS-1:0];
    endfunction

    function automatic logic [40:0] clamp_scl(input logic [63:0] ph, input logic [63:0] pl);
        logic [48:0] f;
        f = 49'({ph[23:0], 16'b0}) + 49'(pl[63:16]);
        if ((ph[63:24] != '0) || (f > 49'(SCL_LIM))) begin
            f = 49'(SCL_LIM);
        end
        return f[40:0];
    endfunction

    assign w_i    = r_cnt[3:0];
    assign w_atan = ANG_W'(atan_q16(w_i));
    assign w_px   = r_cx * INV_MM2;
    assign w_py   = r_cy * INV_MM2;
    assign w_tx   = {r_remx, r_qx[NUM_W-1]};
    assign w_ty   = {r_remy, r_qy[NUM_W-1]};
    assign w_gx   = w_tx >= {1'b0, r_den};
    assign w_gy   = w_ty >= {1'b0, r_den};
    assign w_ax   = r_sx[ACC_BITS-1] ? -64'(r_sx) : 64'(r_sx);
    assign w_ay   = r_sy[ACC_BITS-1] ? -64'(r_sy) : 64'(r_sy);
    assign w_bx   = i_cfg.scale_x[31] ? -i_cfg.scale_x : i_cfg.scale_x;
    assign w_by   = i_cfg.scale_y[31] ? -i_cfg.scale_y : i_cfg.scale_y;
    assign w_fx   = 49'(clamp_scl(r_phx, r_plx));
    assign w_fy   = 49'(clamp_scl(r_phy, r_ply));
    assign w_ox   = (r_sgx ? -$signed({2'b0, r_mgx}) : $signed({2'b0, r_mgx}))
                    + 43'(i_cfg.offset_x);
    assign w_oy   = (r_sgy ? -$signed({2'b0, r_mgy}) : $signed({2'b0, r_mgy}))
                    + 43'(i_cfg.offset_y);
    assign w_rb   = r_r + r_bit;
    assign w_zh   = r_z >>> 1;
    assign w_bg   = i_cfg.speed_gain[31] ? -i_cfg.speed_gain : i_cfg.speed_gain;
    assign w_dang = 17'(r_ang) - 17'(r_prev);
    assign w_sp   = r_spneg ? -$signed({16'b0, r_spp[63:16]}) : $signed({16'b0, r_spp[63:16]});
    assign w_st   = 50'(r_stp) + 50'(r_std);
    assign w_out_ok = !r_out_valid || o_cmd.ready;

    assign o_q_pop            = (r_state == S_IDLE) && i_q_valid;
    assign o_cmd.valid        = r_out_valid;
    assign o_cmd.speed_cmd    = r_spd;
    assign o_cmd.steering_cmd = r_str;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_cmd.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_last <= i_q_data.last;
                        r_z    <= i_q_data.ang;
                        r_rng  <= i_q_data.rng[RANGE_BITS-1:0];
                        r_cx   <= CORDIC_GAIN;
                        r_cy   <= '0;
                        r_cnt  <= '0;
                        if (i_q_data.contrib) begin
                            r_state <= S_ROT;
                        end else if (i_q_data.last) begin
                            r_state <= S_SC1;
                        end
                    end
                end
                S_ROT: begin
                    if (!r_z[ANG_W-1]) begin
                        r_cx <= r_cx - (r_cy >>> w_i);
                        r_cy <= r_cy + (r_cx >>> w_i);
                        r_z  <= r_z - w_atan;
                    end else begin
                        r_cx <= r_cx + (r_cy >>> w_i);
                        r_cy <= r_cy - (r_cx >>> w_i);
                        r_z  <= r_z + w_atan;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'(CORDIC_STEPS - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_qx   <= NUM_W'(w_px[40] ? -w_px : w_px);
                    r_qy   <= NUM_W'(w_py[40] ? -w_py : w_py);
                    r_negx <= r_cx[19];
                    r_negy <= r_cy[19];
                    r_den  <= DEN_W'(r_rng * r_rng);
                    r_remx <= '0;
                    r_remy <= '0;
                    r_cnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_remx <= DEN_W'(w_gx ? w_tx - {1'b0, r_den} : w_tx);
                    r_remy <= DEN_W'(w_gy ? w_ty - {1'b0, r_den} : w_ty);
                    r_qx   <= {r_qx[NUM_W-2:0], w_gx};
                    r_qy   <= {r_qy[NUM_W-2:0], w_gy};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == 6'(NUM_W - 1)) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sx    <= sat_acc(r_sx, r_qx, r_negx);
                    r_sy    <= sat_acc(r_sy, r_qy, r_negy);
                    r_state <= r_last ? S_SC1 : S_IDLE;
                end
                S_SC1: begin
                    r_phx   <= 64'(w_ax[63:32]) * 64'(w_bx);
                    r_plx   <= 64'(w_ax[31:0]) * 64'(w_bx);
                    r_phy   <= 64'(w_ay[63:32]) * 64'(w_by);
                    r_ply   <= 64'(w_ay[31:0]) * 64'(w_by);
                    r_sgx   <= r_sx[ACC_BITS-1] ^ i_cfg.scale_x[31];
                    r_sgy   <= r_sy[ACC_BITS-1] ^ i_cfg.scale_y[31];
                    r_state <= S_SC2;
                end
                S_SC2: begin
                    r_mgx   <= w_fx[40:0];
                    r_mgy   <= w_fy[40:0];
                    r_state <= S_SC3;
                end
                S_SC3: begin
                    r_nx    <= sat32(64'(w_ox));
                    r_ny    <= sat32(64'(w_oy));
                    r_state <= S_VI;
                end
                S_VI: begin
                    r_sqx <= $unsigned(64'(r_nx) * 64'(r_nx));
                    r_sqy <= $unsigned(64'(r_ny) * 64'(r_ny));
                    r_byp <= (r_ny == '0);
                    if (r_ny == '0) begin
                        r_z <= r_nx[31] ? PI_Q16 : '0;
                    end else if (r_nx[31]) begin
                        r_z  <= r_ny[31] ? -PI_Q16 : PI_Q16;
                        r_vx <= -VW'(r_nx);
                        r_vy <= -VW'(r_ny);
                    end else begin
                        r_z  <= '0;
                        r_vx <= VW'(r_nx);
                        r_vy <= VW'(r_ny);
                    end
                    r_cnt   <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_v     <= r_sqx + r_sqy;
                    r_r     <= '0;
                    r_bit   <= 64'h4000_0000_0000_0000;
                    r_state <= S_VEC;
                end
                S_VEC: begin
                    if (r_v >= w_rb) begin
                        r_v <= r_v - w_rb;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (!r_byp && !r_cnt[4]) begin
                        if (r_vy > 0) begin
                            r_vx <= r_vx + (r_vy >>> w_i);
                            r_vy <= r_vy - (r_vx >>> w_i);
                            r_z  <= r_z + w_atan;
                        end else begin
                            r_vx <= r_vx - (r_vy >>> w_i);
                            r_vy <= r_vy + (r_vx >>> w_i);
                            r_z  <= r_z - w_atan;
                        end
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'd31) begin
                        r_state <= S_ANG;
                    end
                end
                S_ANG: begin
                    if (w_zh > ANG_W'(ANG_LIM)) begin
                        r_ang <= ANG_LIM;
                    end else if (w_zh < -ANG_W'(ANG_LIM)) begin
                        r_ang <= -ANG_LIM;
                    end else begin
                        r_ang <= w_zh[15:0];
                    end
                    r_mag   <= r_r[31:0];
                    r_state <= S_PRD;
                end
                S_PRD: begin
                    r_spp   <= 64'(w_bg) * 64'(r_mag);
                    r_spneg <= i_cfg.speed_gain[31] ^ r_nx[31];
                    r_stp   <= 48'(i_cfg.steer_p_gain) * 48'(r_ang);
                    r_std   <= 49'(i_cfg.steer_d_gain) * 49'(w_dang);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_ok) begin
                        r_spd       <= sat32(w_sp);
                        r_str       <= sat32(64'(w_st >>> 15));
                        r_out_valid <= 1'b1;
                        r_prev      <= r_ang;
                        r_sx        <= '0;
                        r_sy        <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### sv/potential_field_steering_unit.sv
// top level of the potential field steering unit
// Channels: i_smp takes one lidar sample per item (range_mm, beam_angle,
// last_sample); o_cmd gives one speed/steering command per scan, on the item
// that carries last_sample. Both use valid/ready, an item moves when both high.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
// (0 scale_x .. 6 steer_d_gain); index 7 is ignored.
// Samples enter a four-entry queue, so the source keeps going while the engine
// works. The engine takes a sample with a return inside the beam window through
// 16 cordic steps, one multiply, 37 restoring divide steps and one accumulate
// (the divider sets the pace), and pops any other sample and adds nothing for it.
// A last sample then goes through scaling, a 16-step vectoring cordic that runs
// alongside a 32-step square root, and the gain products.
// The command sits in an output register; a stalled receiver holds the engine
// only at the point of writing the next command, and intake goes on until the
// queue fills.
// Reset clears the queue, the sums, the stored angle and the output, and loads
// the register defaults.
`default_nettype none
module potential_field_steering_unit #(
    parameter int RANGE_BITS = 16,
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int ACC_BITS = 48
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    pfs_sample_if.sink                  i_smp,
    pfs_cmd_if.source                   o_cmd,
    input  wire                         i_cfg_we,
    input  wire [pfs_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire [pfs_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import pfs_pkg::*;

    t_cfg    r_cfg;
    logic    w_q_valid;
    logic    w_q_pop;
    t_sample w_q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_x      <= 32'sd4588;
            r_cfg.scale_y      <= 32'sd4588;
            r_cfg.offset_x     <= 32'sd6553600;
            r_cfg.offset_y     <= 32'sd0;
            r_cfg.speed_gain   <= 32'sd3277;
            r_cfg.steer_p_gain <= 32'sd65536;
            r_cfg.steer_d_gain <= 32'sd6554;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SCALE_X:  r_cfg.scale_x      <= i_cfg_wdata;
                REG_SCALE_Y:  r_cfg.scale_y      <= i_cfg_wdata;
                REG_OFFSET_X: r_cfg.offset_x     <= i_cfg_wdata;
                REG_OFFSET_Y: r_cfg.offset_y     <= i_cfg_wdata;
                REG_SPEED_G:  r_cfg.speed_gain   <= i_cfg_wdata;
                REG_STEER_P:  r_cfg.steer_p_gain <= i_cfg_wdata;
                REG_STEER_D:  r_cfg.steer_d_gain <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    pfs_front #(
        .RANGE_BITS      (RANGE_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_smp     (i_smp),
        .o_q_valid (w_q_valid),
        .o_q_data  (w_q_data),
        .i_q_pop   (w_q_pop)
    );

    pfs_back #(
        .RANGE_BITS (RANGE_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_q_pop),
        .i_cfg     (r_cfg),
        .o_cmd     (o_cmd)
    );

endmodule
`default_nettype wire

### sv/pfs_check.sv
// port-level checks for the potential field steering unit, bound to the top level
`default_nettype none
module pfs_check (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire i_in_ready,
    input wire i_in_last,
    input wire i_out_valid,
    input wire i_out_ready,
    input wire [31:0] i_out_speed,
    input wire [31:0] i_out_steer
);
    logic [3:0] r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 4'(i_in_valid && i_in_ready && i_in_last)
                      - 4'(i_out_valid && i_out_ready);
        end
    end

    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("command valid after reset");

    a_out_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != '0)
        else $error("command without a pending last sample");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_speed)
            && $stable(i_out_steer))
        else $error("stalled command changed");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 4'd6)
        else $error("too many scans in flight");

endmodule

bind potential_field_steering_unit pfs_check u_pfs_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_in_last   (i_smp.last_sample),
    .i_out_valid (o_cmd.valid),
    .i_out_ready (o_cmd.ready),
    .i_out_speed (o_cmd.speed_cmd),
    .i_out_steer (o_cmd.steering_cmd)
);
`default_nettype wire
